[rtl/euic_pkg.sv]
// euic_pkg: shared widths, codes, decoder phase type and log2 helper
// for the universal integer codec. No dependencies.
`default_nettype none

package euic_pkg;

	// Fixed field widths of the word channels
	localparam int VALUE_W = 16;
	localparam int CODE_W  = 64;
	localparam int LEN_W   = 7;
	localparam int KIND_W  = 2;
	localparam int CK_W    = 2;
	localparam int ZC_W    = 6;
	localparam int LOG_W   = 5;

	// Parameter defaults
	localparam int DEF_VALUE_BITS = 16;
	localparam int DEF_MAX_UNARY  = 63;

	// Code kind register values
	localparam logic [CK_W-1:0] CK_UNARY = 2'd0;
	localparam logic [CK_W-1:0] CK_GAMMA = 2'd1;
	localparam logic [CK_W-1:0] CK_DELTA = 2'd2;

	// Function codes of an input word
	localparam logic FN_ENC = 1'b0;
	localparam logic FN_DEC = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] RK_ENC = 2'd0;
	localparam logic [KIND_W-1:0] RK_DEC = 2'd1;
	localparam logic [KIND_W-1:0] RK_ERR = 2'd2;

	// Delta prefix runs of this many zeros or more are always oversized
	localparam int DELTA_ZC_LIM = 6;

	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_ZEROS = 4'b0010,
		PH_LEN   = 4'b0100,
		PH_BODY  = 4'b1000
	} dec_phase_t;

	// Position of the leading one (zero for x of zero or one)
	function automatic logic [LOG_W-1:0] flog2(input logic [VALUE_W:0] x);
		logic [LOG_W-1:0] n;
		n = '0;
		for (int i = 1; i <= VALUE_W; i++) begin
			if (x[i]) begin
				n = LOG_W'(i);
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

[rtl/euic_if.sv]
// euic_if: valid/ready word channels of the codec, command side and result side.
// Depends on euic_pkg for field widths.
`default_nettype none

interface euic_cmd_if
	import euic_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               func;
	logic [VALUE_W-1:0] value;
	logic               stream_bit;

	modport source (output valid, func, value, stream_bit, input ready);
	modport sink   (input valid, func, value, stream_bit, output ready);
endinterface

interface euic_res_if
	import euic_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  kind;
	logic [CODE_W-1:0]  code_bits;
	logic [LEN_W-1:0]   code_length;
	logic [VALUE_W-1:0] decoded_value;

	modport source (output valid, kind, code_bits, code_length, decoded_value, input ready);
	modport sink   (input valid, kind, code_bits, code_length, decoded_value, output ready);
endinterface

`default_nettype wire

[rtl/elias_universal_integer_codec.sv]
// elias_universal_integer_codec: unary / Elias gamma / Elias delta encoder and
// bit-serial decoder. Depends on euic_pkg and the channels in euic_if.sv.
`default_nettype none

//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+------------------------------------------
//  cmd      | in  | valid / ready    | func, value[15:0], stream_bit
//  res      | out | valid / ready    | kind, code_bits[63:0], code_length[6:0],
//           |     |                  | decoded_value[15:0]
//  cfg      | in  | cfg_write        | cfg_data[1:0] -> code_kind
//
//  One word per cycle sustained while res takes results. A word is captured in the
//  input stage, worked through the encoder or one step of the decoder, and moves
//  into the result register when the input stage advances; res takes it from there.
//  A decode word that does not complete a code word leaves no result.
//  Reset puts code_kind at delta and the decoder at the start of a code word;
//  a code_kind write also restarts the decoder.
//  cmd.ready drops only while the input stage holds a word and a result is
//  waiting that res does not take in this cycle.

module elias_universal_integer_codec
	import euic_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int MAX_UNARY  = DEF_MAX_UNARY
) (
	input  wire            clk,
	input  wire            arst_n,
	euic_cmd_if.sink       cmd,
	euic_res_if.source     res,
	input  wire            cfg_write,
	input  wire [CK_W-1:0] cfg_data
);

	// Width of a prefix length or bit count (0..VALUE_BITS)
	localparam int PL_W = $clog2(VALUE_BITS + 1);
	localparam logic [VALUE_BITS:0] PONE = (VALUE_BITS + 1)'(1);
	// First value that no longer fits VALUE_BITS
	localparam logic [VALUE_W:0] VLIM = (VALUE_W + 1)'(1) << VALUE_BITS;

	// ---------------------------------------------------------------------
	// Configuration and decoder state
	// ---------------------------------------------------------------------
	logic [CK_W-1:0]       ck_q;
	dec_phase_t            phase_q, phase_nxt;
	logic [ZC_W-1:0]       zc_q, zc_nxt;
	logic [PL_W-1:0]       pl_q, pl_nxt;
	logic [PL_W-1:0]       bl_q, bl_nxt;
	logic [VALUE_BITS-1:0] acc_q, acc_nxt;

	// ---------------------------------------------------------------------
	// Input stage
	// ---------------------------------------------------------------------
	logic               vld_s1;
	logic               func_s1;
	logic [VALUE_W-1:0] value_s1;
	logic               bit_s1;

	// Result stage
	logic               vld_s2;
	logic [KIND_W-1:0]  kind_s2;
	logic [CODE_W-1:0]  bits_s2;
	logic [LEN_W-1:0]   len_s2;
	logic [VALUE_W-1:0] dec_s2;

	logic out_free;
	logic adv;

	// Advance the input stage whenever the result register can take a word
	assign out_free  = !vld_s2 || res.ready;
	assign adv       = vld_s1 && out_free;
	assign cmd.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			func_s1  <= cmd.func;
			value_s1 <= cmd.value;
			bit_s1   <= cmd.stream_bit;
		end
	end

	// ---------------------------------------------------------------------
	// Single-pass work: encode, or one decoder step
	// ---------------------------------------------------------------------
	logic               r_has;
	logic [KIND_W-1:0]  r_kind;
	logic [CODE_W-1:0]  r_bits;
	logic [LEN_W-1:0]   r_len;
	logic [VALUE_W-1:0] r_dec;

	logic [VALUE_W:0]   enc_x;
	logic [LOG_W-1:0]   enc_n;
	logic [LOG_W-1:0]   enc_g;
	logic [LOG_W-1:0]   enc_m;
	logic [VALUE_W:0]   enc_low;
	logic [VALUE_W+LOG_W-1:0] enc_dbits;

	// Encoder: x = value + 1, n = floor(log2 x)
	always_comb begin
		enc_x     = {1'b0, value_s1} + (VALUE_W + 1)'(1);
		enc_n     = flog2(enc_x);
		enc_g     = enc_n + LOG_W'(1);
		enc_m     = flog2((VALUE_W + 1)'(enc_g));
		// Drop the leading one of x, keep its n low bits
		enc_low   = enc_x & (((VALUE_W + 1)'(1) << enc_n) - (VALUE_W + 1)'(1));
		enc_dbits = ((VALUE_W + LOG_W)'(enc_g) << enc_n) | (VALUE_W + LOG_W)'(enc_low);
	end

	logic [ZC_W:0]         zc_inc;
	logic [VALUE_BITS-1:0] acc_sh;
	logic [PL_W-1:0]       bl_dec;
	logic [VALUE_BITS:0]   dec_t;
	logic [ZC_W-1:0]       delta_span;
	logic                  dec_fail;

	always_comb begin
		r_has      = 1'b0;
		r_kind     = RK_ERR;
		r_bits     = '0;
		r_len      = '0;
		r_dec      = '0;
		phase_nxt  = phase_q;
		zc_nxt     = zc_q;
		pl_nxt     = pl_q;
		bl_nxt     = bl_q;
		acc_nxt    = acc_q;
		dec_fail   = 1'b0;

		zc_inc     = {1'b0, zc_q} + (ZC_W + 1)'(1);
		acc_sh     = {acc_q[VALUE_BITS-2:0], bit_s1};
		bl_dec     = (bl_q != '0) ? bl_q - PL_W'(1) : bl_q;
		// 2^prefix - 1 + accumulated bits
		dec_t      = (PONE << pl_q) - PONE + (VALUE_BITS + 1)'(acc_sh);
		delta_span = (ZC_W'(1) << zc_inc[2:0]) - ZC_W'(1);

		if (func_s1 == FN_ENC) begin
			r_has = 1'b1;
			if (ck_q == CK_UNARY && {1'b0, value_s1} < VLIM
					&& value_s1 <= VALUE_W'(MAX_UNARY)) begin
				r_kind = RK_ENC;
				r_bits = CODE_W'(1);
				r_len  = LEN_W'(value_s1) + LEN_W'(1);
			end else if (ck_q == CK_GAMMA && {1'b0, value_s1} < VLIM) begin
				r_kind = RK_ENC;
				r_bits = CODE_W'(enc_x);
				r_len  = LEN_W'({enc_n, 1'b1});
			end else if (ck_q == CK_DELTA && {1'b0, value_s1} < VLIM) begin
				r_kind = RK_ENC;
				r_bits = CODE_W'(enc_dbits);
				r_len  = LEN_W'({enc_m, 1'b1}) + LEN_W'(enc_n);
			end
		end else if (ck_q == CK_UNARY) begin
			if (bit_s1) begin
				r_has  = 1'b1;
				r_kind = RK_DEC;
				r_dec  = VALUE_W'(zc_q);
				zc_nxt = '0;
			end else if (zc_inc > (ZC_W + 1)'(MAX_UNARY)) begin
				dec_fail = 1'b1;
			end else begin
				zc_nxt = zc_inc[ZC_W-1:0];
			end
		end else if (ck_q == CK_GAMMA || ck_q == CK_DELTA) begin
			case (phase_q)
				PH_START: begin
					if (bit_s1) begin
						r_has  = 1'b1;
						r_kind = RK_DEC;
					end else begin
						zc_nxt    = ZC_W'(1);
						phase_nxt = PH_ZEROS;
					end
				end
				PH_ZEROS: begin
					if (!bit_s1) begin
						zc_nxt = zc_inc[ZC_W-1:0];
						if (ck_q == CK_GAMMA) begin
							dec_fail = zc_inc > (ZC_W + 1)'(VALUE_BITS);
						end else begin
							dec_fail = zc_inc >= (ZC_W + 1)'(DELTA_ZC_LIM)
								|| delta_span > ZC_W'(VALUE_BITS);
						end
					end else begin
						pl_nxt    = PL_W'(zc_q);
						bl_nxt    = PL_W'(zc_q);
						acc_nxt   = '0;
						phase_nxt = PH_LEN;
					end
				end
				PH_LEN, PH_BODY: begin
					acc_nxt = acc_sh;
					bl_nxt  = bl_dec;
					if (bl_dec == '0) begin
						if (ck_q == CK_DELTA && phase_q == PH_LEN) begin
							// Length field done: go read the body bits
							if (dec_t > (VALUE_BITS + 1)'(VALUE_BITS)) begin
								dec_fail = 1'b1;
							end else begin
								pl_nxt    = PL_W'(dec_t);
								bl_nxt    = PL_W'(dec_t);
								acc_nxt   = '0;
								phase_nxt = PH_BODY;
							end
						end else if (dec_t[VALUE_BITS]) begin
							dec_fail = 1'b1;
						end else begin
							r_has     = 1'b1;
							r_kind    = RK_DEC;
							r_dec     = VALUE_W'(dec_t[VALUE_BITS-1:0]);
							phase_nxt = PH_START;
							zc_nxt    = '0;
							pl_nxt    = '0;
							bl_nxt    = '0;
							acc_nxt   = '0;
						end
					end
				end
				default: begin
					dec_fail = 1'b1;
				end
			endcase
		end else begin
			// Unused code kind
			dec_fail = 1'b1;
		end

		// A completed code word or any decode error restarts the decoder
		if (dec_fail) begin
			r_has  = 1'b1;
			r_kind = RK_ERR;
			r_dec  = '0;
		end
		if (func_s1 == FN_DEC && (dec_fail || (r_has && ck_q != CK_UNARY))) begin
			phase_nxt = PH_START;
			zc_nxt    = '0;
			pl_nxt    = '0;
			bl_nxt    = '0;
			acc_nxt   = '0;
		end
		if (func_s1 == FN_DEC && dec_fail) begin
			zc_nxt = '0;
		end
	end

	// Decoder state: a code_kind write restarts it, otherwise step on decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ck_q    <= CK_DELTA;
			phase_q <= PH_START;
			zc_q    <= '0;
			pl_q    <= '0;
			bl_q    <= '0;
			acc_q   <= '0;
		end else if (cfg_write) begin
			ck_q    <= cfg_data;
			phase_q <= PH_START;
			zc_q    <= '0;
			pl_q    <= '0;
			bl_q    <= '0;
			acc_q   <= '0;
		end else if (adv && func_s1 == FN_DEC) begin
			phase_q <= phase_nxt;
			zc_q    <= zc_nxt;
			pl_q    <= pl_nxt;
			bl_q    <= bl_nxt;
			acc_q   <= acc_nxt;
		end
	end

	// ---------------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (out_free) begin
			vld_s2 <= adv && r_has;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && r_has) begin
			kind_s2 <= r_kind;
			bits_s2 <= r_bits;
			len_s2  <= r_len;
			dec_s2  <= r_dec;
		end
	end

	assign res.valid         = vld_s2;
	assign res.kind          = kind_s2;
	assign res.code_bits     = bits_s2;
	assign res.code_length   = len_s2;
	assign res.decoded_value = dec_s2;

	// ---------------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------------
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write |=> (phase_q == PH_START && zc_q == '0 && acc_q == '0))
		else $error("decoder not restarted by code_kind write");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !adv) |=> (vld_s1 && $stable(value_s1) && $stable(func_s1)))
		else $error("input stage lost or changed a stalled word");

	a_enc_len: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && kind_s2 == RK_ENC) |-> (len_s2 != '0 && len_s2 <= LEN_W'(CODE_W)))
		else $error("encoded word with impossible length");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && kind_s2 == RK_ERR) |-> (bits_s2 == '0 && len_s2 == '0 && dec_s2 == '0))
		else $error("error result carries payload");

endmodule

`default_nettype wire
